@@ rtl/core/hsfd_pkg.sv @@
`timescale 1ns / 1ps

package hsfd_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_HEADER_WORD = 8'd0;
    localparam logic [7:0] CFG_STOP_BYTE   = 8'd1;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int WIN_SIZE = 4;

    typedef struct packed {
        logic [31:0] header_word;
        logic [7:0]  stop_byte;
    } hsfd_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_STOP,
        ST_RD,
        ST_SHIFT,
        ST_EMIT,
        ST_ERR
    } state_t;

    // Expected header byte k, first expected byte in the top bits
    function automatic logic [7:0] header_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            2'd3:    b = w[7:0];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/hsfd_payload_ram.sv @@
`timescale 1ns / 1ps

module hsfd_payload_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte, read one byte, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/hsfd_core.sv @@
`timescale 1ns / 1ps

module hsfd_core import hsfd_pkg::*; #(
    parameter int WORDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  hsfd_cfg_t   cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  rx_byte,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] payload_word,
    output logic [5:0]  word_index,
    output logic        last_word,
    output logic        stop_error
);

    localparam int PB     = 4 * WORDS;
    localparam int ADDR_W = $clog2(PB);
    localparam int CNT_W  = $clog2(PB + 1);
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    state_t state_reg, state_next;

    logic [7:0]        window_reg [WIN_SIZE];
    logic [1:0]        pos_reg;
    logic              capturing_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        k_reg;
    logic              hit_reg;
    logic              hit_next;
    logic [7:0]        byte_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [1:0]        bsel_reg;
    logic [31:0]       word_reg;

    logic              out_valid_reg;
    logic [31:0]       out_word_reg;
    logic [5:0]        out_index_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic              s_accept;
    logic              load_ok;
    logic              out_load;
    logic              payload_full;
    logic              last_idx;
    logic              ram_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        cmp_a;
    logic [7:0]        cmp_b;
    logic              cmp_eq;

    assign s_accept     = s_tvalid && s_tready;
    assign load_ok      = !out_valid_reg || m_tready;
    assign out_load     = load_ok && (state_reg == ST_EMIT || state_reg == ST_ERR);
    assign payload_full = (count_reg == CNT_W'(PB));
    assign last_idx     = (widx_reg == WIDX_W'(WORDS - 1));
    assign rd_addr      = ADDR_W'({widx_reg, bsel_reg});

    // Shared byte comparator: header window while hunting, stop byte at frame end
    always_comb begin
        if (state_reg == ST_CMP) begin
            cmp_a = window_reg[pos_reg + k_reg];
            cmp_b = header_byte(cfg.header_word, k_reg);
        end else begin
            cmp_a = byte_reg;
            cmp_b = cfg.stop_byte;
        end
    end
    assign cmp_eq   = (cmp_a == cmp_b);
    assign hit_next = ((k_reg == 2'd0) ? 1'b1 : hit_reg) && cmp_eq;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!capturing_reg) begin
                        state_next = ST_CMP;
                    end else if (payload_full) begin
                        state_next = ST_STOP;
                    end
                end
            end
            ST_CMP: begin
                if (k_reg == 2'd3) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STOP:  state_next = cmp_eq ? ST_RD : ST_ERR;
            ST_RD:    state_next = ST_SHIFT;
            ST_SHIFT: state_next = (bsel_reg == 2'd3) ? ST_EMIT : ST_RD;
            ST_EMIT: begin
                if (load_ok) begin
                    state_next = last_idx ? ST_IDLE : ST_RD;
                end
            end
            ST_ERR: begin
                if (load_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && capturing_reg && !payload_full;
            end
            default: begin
                s_tready = 1'b0;
                ram_we   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < WIN_SIZE; i++) begin
                window_reg[i] <= '0;
            end
            pos_reg       <= '0;
            capturing_reg <= 1'b0;
            count_reg     <= '0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            widx_reg      <= '0;
            bsel_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (!capturing_reg) begin
                            window_reg[pos_reg] <= rx_byte;
                            pos_reg             <= pos_reg + 2'd1;
                            k_reg               <= '0;
                        end else if (!payload_full) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            capturing_reg <= 1'b0;
                            count_reg     <= '0;
                            widx_reg      <= '0;
                            bsel_reg      <= '0;
                        end
                    end
                end
                ST_CMP: begin
                    hit_reg <= hit_next;
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg == 2'd3 && hit_next) begin
                        capturing_reg <= 1'b1;
                        count_reg     <= '0;
                    end
                end
                ST_SHIFT: begin
                    bsel_reg <= bsel_reg + 2'd1;
                end
                ST_EMIT: begin
                    if (load_ok && !last_idx) begin
                        widx_reg <= widx_reg + WIDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload path, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_accept) begin
            byte_reg <= rx_byte;
        end
        if (state_reg == ST_SHIFT) begin
            word_reg <= {word_reg[23:0], rd_data};
        end
        if (state_reg == ST_EMIT && load_ok) begin
            out_word_reg  <= word_reg;
            out_index_reg <= INDEX_W'(widx_reg);
            out_last_reg  <= last_idx;
            out_err_reg   <= 1'b0;
        end
        if (state_reg == ST_ERR && load_ok) begin
            out_word_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b1;
            out_err_reg   <= 1'b1;
        end
    end

    hsfd_payload_ram #(
        .DEPTH  (PB),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid     = out_valid_reg;
    assign payload_word = out_word_reg;
    assign word_index   = out_index_reg;
    assign last_word    = out_last_reg;
    assign stop_error   = out_err_reg;

endmodule

@@ rtl/core/header_sync_frame_deframer_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Word fields (low bit up)
// s_        in         tdata: rx_byte[7:0]
// m_        out        tdata: payload_word[31:0], word_index[37:32], zero[39:38];
//                      tlast: last_word; tuser: stop_error
// cfg_      in         cfg_index selects register, cfg_data carries value
//
// A header-hunt byte is accepted, then its window is checked one byte per
// cycle through the shared byte comparator. A payload byte is written to the
// payload RAM as it is accepted. A stop byte is registered, then checked; a
// good frame then drains every word (4 reads of the payload RAM, one byte each,
// then the output load) before the next byte is taken; a bad stop sets stop_error.
// Reset (aresetn low, synchronous) clears the window, counters, config and
// output valid; the payload RAM is not cleared. A stalled m_ side holds the
// drain at the output load step; the result register frees the input side.

module header_sync_frame_deframer_top import hsfd_pkg::*; #(
    parameter int WORDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] payload_word, [37:32] word_index, [39:38] zero
    output logic        m_tlast,   // last_word
    output logic [0:0]  m_tuser,   // [0] stop_error
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    hsfd_cfg_t   cfg_reg;
    logic [31:0] payload_word;
    logic [5:0]  word_index;
    logic        last_word;
    logic        stop_error;

    // Always take config words; unknown indexes drop
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEADER_WORD: cfg_reg.header_word <= cfg_data;
                CFG_STOP_BYTE:   cfg_reg.stop_byte   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, window compare and drain
    hsfd_core #(
        .WORDS (WORDS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .rx_byte      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .payload_word (payload_word),
        .word_index   (word_index),
        .last_word    (last_word),
        .stop_error   (stop_error)
    );

    // Pack the result word
    assign m_tdata = {2'b00, word_index, payload_word};
    assign m_tlast = last_word;
    assign m_tuser = stop_error;

endmodule
